// ===== src/lru_key_value_cache_macros.svh =====
// assertion macros for the lru key-value cache
// used by files that check their own control logic; needs clk and rst in scope
`ifndef LRU_KEY_VALUE_CACHE_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_MACROS_SVH

// same-cycle implication, checked outside reset
`define LKVC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lkvc same-cycle check failed");

// next-cycle implication, checked outside reset
`define LKVC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lkvc next-cycle check failed");

`endif

// ===== src/lkvc_pkg.sv =====
// shared types and constants for the lru key-value cache
// no dependencies; used by lkvc_cell and lru_key_value_cache
`timescale 1ns / 1ps

package lkvc_pkg;

  localparam int MAX_ENTRIES_DEF = 16;
  localparam int DATA_W          = 32;
  localparam int CAP_W           = 5;
  localparam int APB_ADDR_W      = 3;
  localparam int APB_DATA_W      = 32;

  localparam logic [CAP_W-1:0]  CAP_RESET  = 5'd16;
  localparam logic [DATA_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

  // register index, taken from paddr above the byte offset
  localparam logic REG_CAPACITY = 1'b0;

  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_UPD
  } state_t;

  // control broadcast to every cell of the chain
  typedef struct packed {
    logic capture;    // latch the key compare
    logic apply;      // commit the shift of this transfer
    logic shift_all;  // put miss: every cell takes its neighbor's entry
  } ctrl_t;

endpackage

// ===== src/lkvc_cell.sv =====
// one entry of the recency chain: key, value, compare and shift
// depends on lkvc_pkg
`timescale 1ns / 1ps

module lkvc_cell #(
  parameter int CNT_W = 5,
  parameter int IDX   = 0
) (
  input  logic                      clk,
  input  lkvc_pkg::ctrl_t           ctrl,
  input  logic [CNT_W-1:0]          count,
  input  logic [lkvc_pkg::DATA_W-1:0] search_key,
  // entry handed in from the more recent neighbor
  input  logic [lkvc_pkg::DATA_W-1:0] left_key,
  input  logic [lkvc_pkg::DATA_W-1:0] left_value,
  // match and found value chains, coming from the less recent side
  input  logic                      below_in,
  input  logic [lkvc_pkg::DATA_W-1:0] found_in,
  output logic                      below_out,
  output logic [lkvc_pkg::DATA_W-1:0] found_out,
  output logic [lkvc_pkg::DATA_W-1:0] entry_key,
  output logic [lkvc_pkg::DATA_W-1:0] entry_value,
  output logic                      match
);

  localparam logic [CNT_W-1:0] POS = CNT_W'(IDX);

  logic valid;
  logic shift;

  // slot holds a live entry while it sits below the fill count
  assign valid = POS < count;

  // key compare, held for the update cycle
  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      match <= valid && (entry_key == search_key);
    end
  end

  // cells up to and including the hit take the entry from their left
  assign below_out = match | below_in;
  assign found_out = match ? entry_value : found_in;
  assign shift     = ctrl.apply && (ctrl.shift_all || below_out);

  always_ff @(posedge clk) begin
    if (shift) begin
      entry_key   <= left_key;
      entry_value <= left_value;
    end
  end

endmodule

// ===== src/lru_key_value_cache.sv =====
// lru key-value cache: each item passes a compare state and then a shift state through the cell chain;
// the next item can be taken as the update state of the last one completes, and a get result is registered then.
// The update state is held only while a get waits for the output register to drain.
// synchronous reset empties the store, sets capacity to 16 and clears out_valid.
// depends on lkvc_pkg, lkvc_cell and lru_key_value_cache_macros.svh
`timescale 1ns / 1ps
`include "lru_key_value_cache_macros.svh"

module lru_key_value_cache #(
  parameter int MAX_ENTRIES = lkvc_pkg::MAX_ENTRIES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // request channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              opcode,
  input  logic signed [lkvc_pkg::DATA_W-1:0] key,
  input  logic signed [lkvc_pkg::DATA_W-1:0] value,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              hit,
  output logic signed [lkvc_pkg::DATA_W-1:0] read_value,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lkvc_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [lkvc_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [lkvc_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int CW    = (CNT_W > lkvc_pkg::CAP_W) ? CNT_W : lkvc_pkg::CAP_W;
  localparam logic [CW-1:0] MAX_CW = CW'(MAX_ENTRIES);
  localparam logic [CW-1:0] ONE_CW = CW'(1);

  lkvc_pkg::state_t state, state_next;
  lkvc_pkg::op_t    op_r;
  logic [lkvc_pkg::DATA_W-1:0] key_r;
  logic [lkvc_pkg::DATA_W-1:0] value_r;
  logic [CNT_W-1:0]            count, count_next;
  logic [lkvc_pkg::CAP_W-1:0]  capacity;

  logic                        accept;
  logic                        upd_done;
  logic                        any_hit;
  logic [lkvc_pkg::DATA_W-1:0] found;
  logic [lkvc_pkg::DATA_W-1:0] head_value;
  logic [CW-1:0]               cap_ext, eff_cap, count_ext;
  lkvc_pkg::ctrl_t             ctrl;
  logic                        cfg_write;

  // chains between neighboring cells
  logic [lkvc_pkg::DATA_W-1:0] key_chain   [MAX_ENTRIES+1];
  logic [lkvc_pkg::DATA_W-1:0] value_chain [MAX_ENTRIES+1];
  logic [lkvc_pkg::DATA_W-1:0] found_chain [MAX_ENTRIES+1];
  logic [MAX_ENTRIES:0]        below_chain;
  logic [MAX_ENTRIES-1:0]      match_vec;

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= lkvc_pkg::CAP_RESET;
    end else if (cfg_write && (paddr[2] == lkvc_pkg::REG_CAPACITY)) begin
      capacity <= pwdata[lkvc_pkg::CAP_W-1:0];
    end
  end

  assign prdata = (paddr[2] == lkvc_pkg::REG_CAPACITY)
                  ? lkvc_pkg::APB_DATA_W'(capacity) : '0;

  // request handshake
  assign upd_done = (state == lkvc_pkg::ST_UPD) &&
                    ((op_r == lkvc_pkg::OP_PUT) || !out_valid || !out_stall);
  assign in_stall = !((state == lkvc_pkg::ST_IDLE) || upd_done);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= lkvc_pkg::op_t'(opcode);
      key_r   <= key;
      value_r <= value;
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lkvc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      lkvc_pkg::ST_IDLE: state_next = accept ? lkvc_pkg::ST_LOOK : lkvc_pkg::ST_IDLE;
      lkvc_pkg::ST_LOOK: state_next = lkvc_pkg::ST_UPD;
      lkvc_pkg::ST_UPD: begin
        if (upd_done) begin
          state_next = accept ? lkvc_pkg::ST_LOOK : lkvc_pkg::ST_IDLE;
        end
      end
      default: state_next = lkvc_pkg::ST_IDLE;
    endcase
  end

  // cell control
  assign any_hit        = below_chain[0];
  assign found          = found_chain[0];
  assign ctrl.capture   = (state == lkvc_pkg::ST_LOOK);
  assign ctrl.apply     = upd_done;
  assign ctrl.shift_all = (op_r == lkvc_pkg::OP_PUT) && !any_hit;

  // new front entry: a get hit keeps its stored value
  assign head_value = (op_r == lkvc_pkg::OP_PUT) ? value_r : found;

  assign key_chain[0]              = key_r;
  assign value_chain[0]            = head_value;
  assign found_chain[MAX_ENTRIES]  = lkvc_pkg::MISS_VALUE;
  assign below_chain[MAX_ENTRIES]  = 1'b0;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    lkvc_cell #(
      .CNT_W (CNT_W),
      .IDX   (i)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .count       (count),
      .search_key  (key_r),
      .left_key    (key_chain[i]),
      .left_value  (value_chain[i]),
      .below_in    (below_chain[i+1]),
      .found_in    (found_chain[i+1]),
      .below_out   (below_chain[i]),
      .found_out   (found_chain[i]),
      .entry_key   (key_chain[i+1]),
      .entry_value (value_chain[i+1]),
      .match       (match_vec[i])
    );
  end

  // fill count: a put miss trims to capacity - 1 and then inserts
  assign cap_ext   = CW'(capacity);
  assign count_ext = CW'(count);

  always_comb begin
    if (cap_ext == '0) begin
      eff_cap = ONE_CW;
    end else if (cap_ext > MAX_CW) begin
      eff_cap = MAX_CW;
    end else begin
      eff_cap = cap_ext;
    end
    count_next = count;
    if (upd_done && ctrl.shift_all) begin
      count_next = (count_ext >= eff_cap) ? eff_cap[CNT_W-1:0]
                                          : CNT_W'(count_ext + ONE_CW);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (upd_done && (op_r == lkvc_pkg::OP_GET)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_done && (op_r == lkvc_pkg::OP_GET)) begin
      hit        <= any_hit;
      read_value <= found;
    end
  end

  // checks
  `LKVC_ASSERT_NOW(a_count_bound, 1'b1, count <= CNT_W'(MAX_ENTRIES))
  `LKVC_ASSERT_NOW(a_single_match, state == lkvc_pkg::ST_UPD, $onehot0(match_vec))
  `LKVC_ASSERT_NOW(a_busy_on_look, state == lkvc_pkg::ST_LOOK, in_stall)
  `LKVC_ASSERT_NEXT(a_get_result, upd_done && (op_r == lkvc_pkg::OP_GET), out_valid)

endmodule
